@@ rtl/core/pst_pkg.sv @@
// Package for the permutation stabilizer table: item structs, function codes,
// status codes and fixed widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

    // Fixed field widths
    localparam int CNT_W   = 7;
    localparam int FUNC_W  = 3;
    localparam int ROW_W   = 6;
    localparam int VTX_W   = 5;
    localparam int STAT_W  = 2;

    // Saved-set stack
    localparam int STACK_SLOTS = 32;
    localparam int SLOT_W      = 5;
    localparam int DEPTH_W     = 6;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_START = 3'd1;
    localparam logic [FUNC_W-1:0] FN_STAB  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_BACK  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Register word index of perm_count
    localparam logic REG_PERM_COUNT = 1'b0;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ROW_W-1:0]  perm_index;
        logic [VTX_W-1:0]  vertex;
        logic [VTX_W-1:0]  image;
    } t_in_item;

    typedef struct packed {
        logic              is_minimal;
        logic [CNT_W-1:0]  valid_count;
        logic [STAT_W-1:0] status;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/core/pst_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/permutation_stabilizer_table.sv @@
// Permutation stabilizer table top level: sequencer, valid set, saved-set stack.
// Depends on pst_pkg and pst_ram.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_data carries one command item
//   (load entry, start, stabilize, backtrack, query). Every item yields exactly
//   one result item on o_out_valid / i_out_stall / o_out_data.
//   One item is in work at a time; o_in_stall is high from the cycle after
//   acceptance until the result is written to the output register.
//   Path to o_out_valid: load, start, unused codes, full/empty stack cases and
//   out-of-range vertices go straight to the done state; backtrack passes a pop
//   state that restores the stack top; stabilize and query scan the table in a
//   scan state, reading one table entry per cycle through one shared image/vertex
//   compare, then pass a drain state. The next item is taken once back in idle.
//   If the receiver stalls, the result holds in the output register and the
//   next item still starts; its result waits in the sequencer until it frees.
//   Reset (synchronous, i_rst_n low) empties the valid set and the stack, sets
//   perm_count to 1 and drops any pending result; the table keeps its contents.
//   perm_count (APB byte address 0) is to be written while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module permutation_stabilizer_table #(
    parameter int MAX_PERMS = 64,
    parameter int MAX_VERTS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command items
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire pst_pkg::t_in_item i_in_data,
    // result items
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output pst_pkg::t_out_item     o_out_data,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    import pst_pkg::*;

    localparam int RW        = (MAX_PERMS > 1) ? $clog2(MAX_PERMS) : 1;
    localparam int VW        = $clog2(MAX_VERTS);
    localparam int TBL_DEPTH = 1 << (RW + VW);
    localparam int SAV_W     = MAX_PERMS + CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [VTX_W-1:0]     r_vtx, n_vtx;
    logic [RW-1:0]        r_idx, n_idx;
    logic [RW-1:0]        r_pidx, n_pidx;
    logic                 r_pend, n_pend;
    logic [MAX_PERMS-1:0] r_mask, n_mask;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic                 r_min, n_min;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [CNT_W-1:0]     r_perm_count;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 in_accept;
    logic                 row_ok;
    logic                 vtx_ok;
    logic [CNT_W-1:0]     start_n;
    logic [MAX_PERMS-1:0] start_mask;
    logic                 tbl_we;
    logic [VTX_W-1:0]     tbl_rdata;
    logic                 sav_we;
    logic [SAV_W-1:0]     sav_rdata;
    logic                 img_lt;
    logic                 img_ne;
    logic                 hit;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Range checks on the incoming item
    assign row_ok = int'(i_in_data.perm_index) < MAX_PERMS;
    assign vtx_ok = int'(i_in_data.vertex) < MAX_VERTS;

    // Saturated start count and its low-ones mask
    assign start_n = (r_perm_count > CNT_W'(MAX_PERMS)) ? CNT_W'(MAX_PERMS) : r_perm_count;
    always_comb begin
        for (int k = 0; k < MAX_PERMS; k++) begin
            start_mask[k] = (CNT_W'(k) < start_n);
        end
    end

    // Permutation table: written by load, read by the scan
    pst_ram #(
        .WIDTH (VTX_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr ({RW'(i_in_data.perm_index), VW'(i_in_data.vertex)}),
        .i_wdata (i_in_data.image),
        .i_raddr ({r_idx, VW'(r_vtx)}),
        .o_rdata (tbl_rdata)
    );

    // Saved-set stack: mask and its count, read at the top for backtrack
    pst_ram #(
        .WIDTH (SAV_W),
        .DEPTH (STACK_SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (sav_we),
        .i_waddr (r_depth[SLOT_W-1:0]),
        .i_wdata ({r_mask, r_count}),
        .i_raddr (SLOT_W'(r_depth - DEPTH_W'(1))),
        .o_rdata (sav_rdata)
    );

    // Shared compare unit: image against vertex
    assign img_lt = tbl_rdata < r_vtx;
    assign img_ne = tbl_rdata != r_vtx;
    assign hit    = (r_func == FN_STAB) ? img_ne : img_lt;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_vtx       = r_vtx;
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_pend      = r_pend;
        n_mask      = r_mask;
        n_count     = r_count;
        n_depth     = r_depth;
        n_min       = r_min;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        tbl_we      = 1'b0;
        sav_we      = 1'b0;

        // drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_func   = i_in_data.func;
                    n_vtx    = i_in_data.vertex;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_min    = 1'b0;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (i_in_data.func)
                        FN_LOAD: begin
                            tbl_we = row_ok && vtx_ok;
                        end
                        FN_START: begin
                            n_mask  = start_mask;
                            n_count = start_n;
                            n_depth = '0;
                        end
                        FN_STAB: begin
                            if (r_depth >= DEPTH_W'(STACK_SLOTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                sav_we  = 1'b1;
                                n_depth = r_depth + DEPTH_W'(1);
                                if (vtx_ok) begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        FN_BACK: begin
                            if (r_depth == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_depth = r_depth - DEPTH_W'(1);
                                n_state = S_POP;
                            end
                        end
                        FN_QUERY: begin
                            n_min = 1'b1;
                            if (vtx_ok) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                // restore the top saved set
                n_mask  = sav_rdata[SAV_W-1:CNT_W];
                n_count = sav_rdata[CNT_W-1:0];
                n_state = S_DONE;
            end
            S_SCAN: begin
                // issue one table read per cycle
                n_pend = 1'b1;
                n_pidx = r_idx;
                n_idx  = r_idx + RW'(1);
                if (r_idx == RW'(MAX_PERMS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_pend  = 1'b0;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.is_minimal  = r_min;
                    n_out.valid_count = r_count;
                    n_out.status      = r_status;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // evaluate the entry read in the previous cycle
        if (r_pend && r_mask[r_pidx] && hit) begin
            if (r_func == FN_STAB) begin
                n_mask[r_pidx] = 1'b0;
                n_count        = r_count - CNT_W'(1);
            end else begin
                n_min = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_mask      <= '0;
            r_count     <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_mask      <= n_mask;
            r_count     <= n_count;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_vtx    <= n_vtx;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_min    <= n_min;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_count <= CNT_W'(1);
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PERM_COUNT) begin
            r_perm_count <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PERM_COUNT) ? {{(32 - CNT_W){1'b0}}, r_perm_count}
                                                 : 32'd0;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ rtl/core/pst_checker.sv @@
// Port-level checker for permutation_stabilizer_table, bound to the top level.
// Depends on pst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pst_checker #(
    parameter int MAX_PERMS = 64
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire pst_pkg::t_out_item o_out_data
);

    import pst_pkg::*;

    // An accepted item keeps the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // A new result appears only while an item is in work
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in work");

    // Count never exceeds the table and status is a defined code
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.valid_count <= CNT_W'(MAX_PERMS))
                        && (o_out_data.status == ST_OK || o_out_data.status == ST_EMPTY
                            || o_out_data.status == ST_FULL))
        else $error("result count or status out of range");

    // Minimal is never reported with an error status (only a query sets it)
    a_min_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_minimal |-> o_out_data.status == ST_OK)
        else $error("minimal flag with error status");

endmodule

bind permutation_stabilizer_table pst_checker #(
    .MAX_PERMS (MAX_PERMS)
) u_pst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
